// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

// Condition never holds.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("assertion failed");

`endif

// ===== design/dmpc_pkg.sv =====
`timescale 1ns / 1ps

package dmpc_pkg;

  localparam int RefPortBits = 32;
  localparam int GenBits     = 32;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'b00,
    OP_INSERT = 2'b01,
    OP_INVAL  = 2'b10,
    OP_NONE   = 2'b11
  } op_e;

  localparam int OpBits = $bits(op_e);

  typedef logic [RefPortBits-1:0] ref_t;
  typedef logic [GenBits-1:0]     gen_t;

endpackage

// ===== design/dmpc_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmpc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth))

endmodule

// ===== design/dmpc_front.sv =====
`timescale 1ns / 1ps

module dmpc_front #(
  parameter int IdxW      = 8,
  parameter int StoreBits = 32
) (
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           command_i,
  input  dmpc_pkg::ref_t       object_ref_i,
  input  dmpc_pkg::ref_t       key_ref_i,
  input  dmpc_pkg::ref_t       key_hash_i,
  input  dmpc_pkg::ref_t       value_ref_i,
  input  logic                 queue_full_i,
  input  logic                 clearing_i,
  output logic                 push_o,
  output dmpc_pkg::op_e        op_o,
  output logic [IdxW-1:0]      idx_o,
  output logic [StoreBits-1:0] obj_o,
  output logic [StoreBits-1:0] key_o,
  output logic [StoreBits-1:0] val_o
);

  import dmpc_pkg::*;

  ref_t hashed;

  assign busy_o = queue_full_i || clearing_i;
  assign push_o = start_i && !busy_o;

  always_comb begin
    case (command_i)
      CMD_LOOKUP: op_o = OP_LOOKUP;
      CMD_INSERT: op_o = OP_INSERT;
      CMD_INVAL:  op_o = OP_INVAL;
      default:    op_o = OP_NONE;
    endcase
  end

  assign obj_o  = object_ref_i[StoreBits-1:0];
  assign key_o  = key_ref_i[StoreBits-1:0];
  assign val_o  = value_ref_i[StoreBits-1:0];
  assign hashed = RefPortBits'(obj_o) ^ key_hash_i;
  assign idx_o  = hashed[IdxW-1:0];

endmodule

// ===== design/dmpc_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmpc_back #(
  parameter int SlotCount = 256,
  parameter int IdxW      = 8,
  parameter int StoreBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  dmpc_pkg::op_e        op_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic [StoreBits-1:0] obj_i,
  input  logic [StoreBits-1:0] key_i,
  input  logic [StoreBits-1:0] val_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 done_o,
  output logic                 hit_o,
  output dmpc_pkg::ref_t       found_value_ref_o
);

  import dmpc_pkg::*;

  localparam int EntryW = GenBits + 3 * StoreBits;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  gen_t                  gen_q, gen_d;

  logic [EntryW-1:0]     mem_q [SlotCount];
  logic [EntryW-1:0]     rdata_q;
  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       waddr;
  logic [EntryW-1:0]     wdata;

  logic                  s2_valid_q, s2_lookup_q;
  logic [StoreBits-1:0]  s2_obj_q, s2_key_q;
  gen_t                  s2_gen_q;

  gen_t                  rd_gen;
  logic [StoreBits-1:0]  rd_obj, rd_key, rd_val;

  assign clearing_o = (state_q == ST_CLEAR);
  assign pop_o      = (state_q == ST_RUN) && head_valid_i;

  assign mem_we = clearing_o || (pop_o && op_i == OP_INSERT);
  assign mem_re = pop_o && op_i == OP_LOOKUP;
  assign waddr  = clearing_o ? cnt_q : idx_i;
  assign wdata  = clearing_o ? '0 : {gen_q, obj_i, key_i, val_i};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    gen_d   = gen_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_q == IdxW'(SlotCount - 1)) begin
          state_d = ST_RUN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RUN: begin
        if (pop_o && op_i == OP_INVAL) begin
          if (gen_q == '1) begin
            gen_d   = GenBits'(1);
            state_d = ST_CLEAR;
            cnt_d   = '0;
          end else begin
            gen_d = gen_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      gen_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      gen_q      <= gen_d;
      s2_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_lookup_q <= (op_i == OP_LOOKUP);
      s2_obj_q    <= obj_i;
      s2_key_q    <= key_i;
      s2_gen_q    <= gen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[idx_i];
    end
  end

  assign rd_val = rdata_q[StoreBits-1:0];
  assign rd_key = rdata_q[2*StoreBits-1:StoreBits];
  assign rd_obj = rdata_q[3*StoreBits-1:2*StoreBits];
  assign rd_gen = rdata_q[EntryW-1:3*StoreBits];

  assign done_o = s2_valid_q;
  assign hit_o  = s2_valid_q && s2_lookup_q && (rd_gen == s2_gen_q)
                  && (rd_obj == s2_obj_q) && (rd_key == s2_key_q);
  assign found_value_ref_o = hit_o ? RefPortBits'(rd_val) : '0;

  `ASSERT_NEXT(a_pop_gives_result, clk_i, rst_ni, pop_o, done_o)
  `ASSERT_NEXT(a_gen_stays_nonzero, clk_i, rst_ni, gen_q != '0, gen_q != '0)
  `ASSERT_IMPLIES(a_no_pop_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !pop_o)

endmodule

// ===== design/direct_mapped_property_cache.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// command   in         start_i && !busy_o             command_i, object_ref_i, key_ref_i,
//                                                     key_hash_i, value_ref_i
// result    out        done_o (one-cycle strobe)      hit_o, found_value_ref_o
//
// Every command gives one result strobe; each command passes through the command
// queue and the result-stage registers before its result appears. A command queued
// behind an invalidate that wraps the generation also waits for the clearing pass.
// Sustained rate is one command per cycle while busy_o is low; the slot store is one
// memory with one write and one registered read port, read by a lookup, written by an insert.
// After reset, and when an invalidate wraps the generation, a clearing pass
// writes every slot, with busy_o high.
// busy_o is also high while the two-entry command queue is full.
// The receiver cannot stall: results are never held.

module direct_mapped_property_cache #(
  parameter int SLOT_COUNT = 256,
  parameter int REF_BITS   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     command_i,
  input  dmpc_pkg::ref_t object_ref_i,
  input  dmpc_pkg::ref_t key_ref_i,
  input  dmpc_pkg::ref_t key_hash_i,
  input  dmpc_pkg::ref_t value_ref_i,
  output logic           done_o,
  output logic           hit_o,
  output dmpc_pkg::ref_t found_value_ref_o
);

  import dmpc_pkg::*;

  localparam int IdxW      = $clog2(SLOT_COUNT);
  localparam int StoreBits = (REF_BITS < RefPortBits) ? REF_BITS : RefPortBits;
  localparam int QW        = OpBits + IdxW + 3 * StoreBits;

  logic                 push, pop, q_empty, q_full, clearing;
  op_e                  f_op, h_op;
  logic [IdxW-1:0]      f_idx, h_idx;
  logic [StoreBits-1:0] f_obj, f_key, f_val, h_obj, h_key, h_val;
  logic [QW-1:0]        q_in, q_out;

  dmpc_front #(
    .IdxW      (IdxW),
    .StoreBits (StoreBits)
  ) u_front (
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .object_ref_i (object_ref_i),
    .key_ref_i    (key_ref_i),
    .key_hash_i   (key_hash_i),
    .value_ref_i  (value_ref_i),
    .queue_full_i (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .op_o         (f_op),
    .idx_o        (f_idx),
    .obj_o        (f_obj),
    .key_o        (f_key),
    .val_o        (f_val)
  );

  assign q_in = {f_op, f_idx, f_obj, f_key, f_val};

  dmpc_fifo #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign h_op  = op_e'(q_out[QW-1 -: OpBits]);
  assign h_idx = q_out[3*StoreBits +: IdxW];
  assign h_obj = q_out[2*StoreBits +: StoreBits];
  assign h_key = q_out[StoreBits +: StoreBits];
  assign h_val = q_out[0 +: StoreBits];

  dmpc_back #(
    .SlotCount (SLOT_COUNT),
    .IdxW      (IdxW),
    .StoreBits (StoreBits)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (!q_empty),
    .op_i              (h_op),
    .idx_i             (h_idx),
    .obj_i             (h_obj),
    .key_i             (h_key),
    .val_i             (h_val),
    .pop_o             (pop),
    .clearing_o        (clearing),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .found_value_ref_o (found_value_ref_o)
  );

endmodule
